@@ rtl/cw_mark_space_run_qualifier_macros.svh @@
// ----------------------------------------------------------------------------
// CW mark/space run qualifier assertion macros
// Shared assertion forms for the run qualifier, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef CW_MARK_SPACE_RUN_QUALIFIER_MACROS_SVH
`define CW_MARK_SPACE_RUN_QUALIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CWMSR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cw_mark_space_run_qualifier: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CWMSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cw_mark_space_run_qualifier: next-cycle check failed");

`endif

@@ rtl/cwmsr_pkg.sv @@
// ----------------------------------------------------------------------------
// CW mark/space run qualifier package
// Types and constants shared by the run qualifier and its serial divider.
// ----------------------------------------------------------------------------
package cwmsr_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;

  localparam logic [7:0] UNIT_RESET = 8'd60;
  localparam logic [7:0] UNIT_MIN = 8'd24;
  localparam logic [7:0] UNIT_MAX = 8'd240;

  localparam logic ACT_FLUSH = 1'b1;

  localparam logic [10:0] PROB_MIN = 11'd1;
  localparam logic [10:0] PROB_MAX = 11'd1023;
  localparam logic [10:0] CONF_ONE = 11'd1024;
  localparam logic signed [10:0] RAW_MID = 11'sd512;
  localparam logic signed [11:0] SNR_FLOOR = -12'sd480;
  localparam logic signed [11:0] SNR_CEIL = 12'sd800;
  localparam int SNR_FLOOR_MAG = 480;
  localparam int SNR_CEIL_MAG = 800;

  localparam int DECIDE_LEVEL = 123 * 1024;

  localparam int NOM_MARK_MIN = 700;
  localparam int NOM_MARK_MAX = 2000;
  localparam int NOM_SPACE_MIN = 500;
  localparam int NOM_SPACE_MAX = 1200;
  localparam int CONF_BASE = 110592;
  localparam int HALF_STEP = 5120000;
  localparam int CONFIRM_CAP = 23;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE,
    ST_MERGE,
    ST_ADD_RUN,
    ST_ADD_CAND,
    ST_CHECK,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ rtl/cwmsr_serial_div.sv @@
// ----------------------------------------------------------------------------
// CW mark/space run qualifier serial divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cwmsr_serial_div import cwmsr_pkg::*; #(
  parameter int NUM_W = COUNT_BITS_DEFAULT + 12,
  parameter int DEN_W = COUNT_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic [NUM_W-1:0] quotient,
  output div_status_t      status
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge = trial >= {1'b0, den_q};
  assign diff = trial - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start) begin
        busy_q <= 1'b1;
        cnt_q <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_q <= numer;
      den_q <= denom;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], ge};
    end
  end

  assign quotient = num_q;
  assign status = '{busy: busy_q, done: done_q};

endmodule

@@ rtl/cw_mark_space_run_qualifier.sv @@
// ----------------------------------------------------------------------------
// CW mark/space run qualifier
// Turns one soft sample per millisecond into confirmed mark and space
// intervals with their durations, mean confidence and mean SNR.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A sample that reports no interval
// goes from transfer to result without the divider. A sample that confirms a
// new run, and a flush that closes an active run, also run the two means
// through a bit-serial divider, one quotient bit per cycle, before the result
// is loaded. A finished result waits in the output register while the next
// item is taken in. The unit_ms register may be written at any time the
// block is idle.
module cw_mark_space_run_qualifier import cwmsr_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [10:0]        mark_probability,
  input  logic [10:0]        sample_confidence,
  input  logic signed [11:0] snr_db,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               interval_valid,
  output logic               interval_is_mark,
  output logic [15:0]        duration_ms,
  output logic [10:0]        mean_confidence,
  output logic signed [10:0] mean_snr_db,
  output logic               key_down,
  output logic               erasure
);

  localparam int LW = COUNT_BITS;
  localparam int CW = COUNT_BITS + 11;
  localparam int SW = COUNT_BITS + 12;
  localparam int NW = COUNT_BITS + 12;

  function automatic logic [LW-1:0] sat_len(input logic [LW-1:0] a, input logic [LW-1:0] b);
    logic [LW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LW] ? {LW{1'b1}} : s[LW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat_conf(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  function automatic logic [SW-1:0] sat_snr(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {a[SW-1], a} + {b[SW-1], b};
    if (s[SW] != s[SW-1]) begin
      return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return s[SW-1:0];
  endfunction

  state_t state, state_next;

  logic [7:0] unit_ms;

  logic          run_active, run_active_next;
  logic          run_mark, run_mark_next;
  logic [LW-1:0] run_length, run_length_next;
  logic [CW-1:0] run_conf_total, run_conf_total_next;
  logic [SW-1:0] run_snr_total, run_snr_total_next;
  logic          cand_active, cand_active_next;
  logic [LW-1:0] cand_length, cand_length_next;
  logic [CW-1:0] cand_conf_total, cand_conf_total_next;
  logic [SW-1:0] cand_snr_total, cand_snr_total_next;
  logic          key_state, key_state_next;
  logic          rep, rep_next;
  logic          rep_mark, rep_mark_next;
  logic [LW-1:0] rep_len, rep_len_next;
  logic          rep_neg, rep_neg_next;

  logic               action_q;
  logic [9:0]         raw_q;
  logic [10:0]        conf_q;
  logic signed [10:0] snr_q;
  logic signed [22:0] d_q;
  logic [27:0]        p_q;

  logic [7:0]         u_c;
  logic [12:0]        nom_m_raw;
  logic [11:0]        nom_s_raw;
  logic [10:0]        nom;
  logic [16:0]        factor;
  logic signed [10:0] diff;
  logic signed [22:0] d_prod;
  logic               decisive;
  logic               want_mark;
  logic               same_kind;
  logic [28:0]        thr;
  logic               confirmed;
  logic               report;
  logic [CW-1:0]      conf_ext;
  logic [SW-1:0]      snr_ext;
  logic [LW-1:0]      cand_base_len;
  logic [CW-1:0]      cand_base_conf;
  logic [SW-1:0]      cand_base_snr;
  logic [SW-1:0]      snr_neg_total;
  logic [NW-1:0]      conf_num;
  logic [NW-1:0]      snr_num;
  logic [NW-1:0]      q_conf;
  logic [NW-1:0]      q_snr;
  div_status_t        div_stat;
  div_status_t        snr_stat;
  logic               div_start;
  logic               out_load;
  logic [LW+15:0]     len_ext;

  // Input capture and the two products of the calculation cycle.
  always_comb begin
    u_c = (unit_ms < UNIT_MIN) ? UNIT_MIN : ((unit_ms > UNIT_MAX) ? UNIT_MAX : unit_ms);
    nom_m_raw = {u_c, 5'b0} - {3'b0, u_c, 2'b0};
    nom_s_raw = {u_c, 4'b0};
    if (run_mark) begin
      if (nom_m_raw < 13'(NOM_MARK_MIN)) nom = 11'(NOM_MARK_MIN);
      else if (nom_m_raw > 13'(NOM_MARK_MAX)) nom = 11'(NOM_MARK_MAX);
      else nom = nom_m_raw[10:0];
    end else begin
      if (nom_s_raw < 12'(NOM_SPACE_MIN)) nom = 11'(NOM_SPACE_MIN);
      else if (nom_s_raw > 12'(NOM_SPACE_MAX)) nom = 11'(NOM_SPACE_MAX);
      else nom = nom_s_raw[10:0];
    end
    factor = 17'(CONF_BASE) - (17'({conf_q, 4'b0}) + 17'({conf_q, 1'b0}));
    diff = $signed({1'b0, raw_q}) - RAW_MID;
    d_prod = $signed(23'({1'b0, conf_q})) * 23'(diff);
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      action_q <= action;
      if (mark_probability < PROB_MIN) raw_q <= PROB_MIN[9:0];
      else if (mark_probability > PROB_MAX) raw_q <= PROB_MAX[9:0];
      else raw_q <= mark_probability[9:0];
      conf_q <= (sample_confidence > CONF_ONE) ? CONF_ONE : sample_confidence;
      if (snr_db < SNR_FLOOR) snr_q <= SNR_FLOOR[10:0];
      else if (snr_db > SNR_CEIL) snr_q <= SNR_CEIL[10:0];
      else snr_q <= snr_db[10:0];
    end
    if (state == ST_CALC) begin
      d_q <= d_prod;
      p_q <= 28'(nom) * 28'(factor);
    end
  end

  // Decision, confirmation and report conditions, and the divider numerators.
  always_comb begin
    want_mark = d_q >= 23'(DECIDE_LEVEL);
    decisive = want_mark || (d_q <= -23'(DECIDE_LEVEL));
    same_kind = !decisive || (want_mark == run_mark);
    thr = 29'({cand_length[4:0], 1'b1}) * 29'(HALF_STEP);
    confirmed = (cand_length >= LW'(CONFIRM_CAP)) || ({1'b0, p_q} < thr);
    report = run_active && (run_length != '0);
    conf_ext = CW'(conf_q);
    snr_ext = {{(SW-11){snr_q[10]}}, snr_q};
    cand_base_len = cand_active ? cand_length : '0;
    cand_base_conf = cand_active ? cand_conf_total : '0;
    cand_base_snr = cand_active ? cand_snr_total : '0;
    snr_neg_total = ~run_snr_total + SW'(1);
    conf_num = NW'(run_conf_total) + NW'(run_length >> 1);
    snr_num = (run_snr_total[SW-1] ? snr_neg_total : run_snr_total) + NW'(run_length >> 1);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CALC;
      end
      ST_CALC: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (action_q == ACT_FLUSH) state_next = ST_MERGE;
        else if (!run_active) state_next = ST_FINISH;
        else if (same_kind) state_next = ST_MERGE;
        else state_next = ST_ADD_CAND;
      end
      ST_MERGE: state_next = (action_q == ACT_FLUSH) ? ST_LOAD : ST_ADD_RUN;
      ST_ADD_RUN: state_next = ST_FINISH;
      ST_ADD_CAND: state_next = ST_CHECK;
      ST_CHECK: state_next = confirmed ? ST_LOAD : ST_FINISH;
      ST_LOAD: state_next = report ? ST_DIV : ST_FINISH;
      ST_DIV: begin
        if (div_stat.done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    div_start = (state == ST_LOAD) && report;
    out_load = (state == ST_FINISH) && (!out_valid || out_ready);
  end

  always_comb begin
    run_active_next = run_active;
    run_mark_next = run_mark;
    run_length_next = run_length;
    run_conf_total_next = run_conf_total;
    run_snr_total_next = run_snr_total;
    cand_active_next = cand_active;
    cand_length_next = cand_length;
    cand_conf_total_next = cand_conf_total;
    cand_snr_total_next = cand_snr_total;
    key_state_next = key_state;
    rep_next = rep;
    rep_mark_next = rep_mark;
    rep_len_next = rep_len;
    rep_neg_next = rep_neg;
    case (state)
      ST_IDLE: begin
        if (in_valid) rep_next = 1'b0;
      end
      ST_DECIDE: begin
        if (action_q != ACT_FLUSH && !run_active && decisive) begin
          run_active_next = 1'b1;
          run_mark_next = want_mark;
          run_length_next = LW'(1);
          run_conf_total_next = conf_ext;
          run_snr_total_next = snr_ext;
          key_state_next = want_mark;
        end
      end
      ST_MERGE: begin
        if (cand_active) begin
          run_length_next = sat_len(run_length, cand_length);
          run_conf_total_next = sat_conf(run_conf_total, cand_conf_total);
          run_snr_total_next = sat_snr(run_snr_total, cand_snr_total);
        end
        cand_active_next = 1'b0;
        cand_length_next = '0;
        cand_conf_total_next = '0;
        cand_snr_total_next = '0;
      end
      ST_ADD_RUN: begin
        run_length_next = sat_len(run_length, LW'(1));
        run_conf_total_next = sat_conf(run_conf_total, conf_ext);
        run_snr_total_next = sat_snr(run_snr_total, snr_ext);
      end
      ST_ADD_CAND: begin
        cand_active_next = 1'b1;
        cand_length_next = sat_len(cand_base_len, LW'(1));
        cand_conf_total_next = sat_conf(cand_base_conf, conf_ext);
        cand_snr_total_next = sat_snr(cand_base_snr, snr_ext);
      end
      ST_LOAD: begin
        rep_next = report;
        rep_mark_next = run_mark;
        rep_len_next = run_length;
        rep_neg_next = run_snr_total[SW-1];
        if (action_q == ACT_FLUSH) begin
          run_active_next = 1'b0;
          run_length_next = '0;
          run_conf_total_next = '0;
          run_snr_total_next = '0;
        end else begin
          run_mark_next = !run_mark;
          run_length_next = cand_length;
          run_conf_total_next = cand_conf_total;
          run_snr_total_next = cand_snr_total;
          cand_active_next = 1'b0;
          cand_length_next = '0;
          cand_conf_total_next = '0;
          cand_snr_total_next = '0;
          key_state_next = !run_mark;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      unit_ms <= UNIT_RESET;
      run_active <= 1'b0;
      run_mark <= 1'b0;
      run_length <= '0;
      run_conf_total <= '0;
      run_snr_total <= '0;
      cand_active <= 1'b0;
      cand_length <= '0;
      cand_conf_total <= '0;
      cand_snr_total <= '0;
      key_state <= 1'b0;
      rep <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) unit_ms <= cfg_data;
      run_active <= run_active_next;
      run_mark <= run_mark_next;
      run_length <= run_length_next;
      run_conf_total <= run_conf_total_next;
      run_snr_total <= run_snr_total_next;
      cand_active <= cand_active_next;
      cand_length <= cand_length_next;
      cand_conf_total <= cand_conf_total_next;
      cand_snr_total <= cand_snr_total_next;
      key_state <= key_state_next;
      rep <= rep_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rep_mark <= rep_mark_next;
    rep_len <= rep_len_next;
    rep_neg <= rep_neg_next;
  end

  cwmsr_serial_div #(
    .NUM_W (NW),
    .DEN_W (LW)
  ) u_conf_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (conf_num),
    .denom    (run_length),
    .quotient (q_conf),
    .status   (div_stat)
  );

  cwmsr_serial_div #(
    .NUM_W (NW),
    .DEN_W (LW)
  ) u_snr_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (snr_num),
    .denom    (run_length),
    .quotient (q_snr),
    .status   (snr_stat)
  );

  assign len_ext = {16'b0, rep_len};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (out_load) begin
      interval_valid <= rep;
      interval_is_mark <= rep && rep_mark;
      duration_ms <= rep ? len_ext[15:0] : 16'd0;
      if (!rep) mean_confidence <= 11'd0;
      else if (q_conf > NW'(CONF_ONE)) mean_confidence <= CONF_ONE;
      else mean_confidence <= q_conf[10:0];
      if (!rep || snr_stat.busy) mean_snr_db <= 11'sd0;
      else if (rep_neg) begin
        if (q_snr > NW'(SNR_FLOOR_MAG)) mean_snr_db <= SNR_FLOOR[10:0];
        else mean_snr_db <= 11'd0 - q_snr[10:0];
      end else begin
        if (q_snr > NW'(SNR_CEIL_MAG)) mean_snr_db <= SNR_CEIL[10:0];
        else mean_snr_db <= q_snr[10:0];
      end
      key_down <= key_state;
      erasure <= cand_active;
    end
  end

`include "cw_mark_space_run_qualifier_macros.svh"

  `CWMSR_ASSERT_IMPLY(a_cand_needs_run, cand_active, run_active)
  `CWMSR_ASSERT_IMPLY(a_run_nonempty, run_active, run_length != '0)
  `CWMSR_ASSERT_IMPLY(a_div_done_in_div, div_stat.done, state == ST_DIV)
  `CWMSR_ASSERT_NEXT(a_div_starts, state == ST_LOAD && report, div_stat.busy && snr_stat.busy)

endmodule

@@ verif/cw_mark_space_run_qualifier_tb.sv @@
// ----------------------------------------------------------------------------
// CW mark/space run qualifier testbench
// Drives soft Morse samples and flushes through the block with random
// bursts and output stalls, predicts every result with an independent model
// of the run and candidate tracking, and compares each result field by field.
// Covers decision thresholds, field extremes, several dot lengths including
// out-of-range ones, a long output hold-off and a run long enough to saturate.
// ----------------------------------------------------------------------------
module testbench;
  import cwmsr_pkg::ACT_FLUSH;

  localparam logic ACT_SAMPLE = ~ACT_FLUSH;
  localparam int CNT_W = cwmsr_pkg::COUNT_BITS_DEFAULT;
  localparam longint LEN_SAT = (longint'(1) << CNT_W) - 1;
  localparam longint CONF_SAT = (longint'(1) << (CNT_W + 11)) - 1;
  localparam longint SNR_BOT = -(longint'(1) << (CNT_W + 11));
  localparam logic [7:0] UNIT_AT_RESET = 8'd60;
  localparam int RANDOM_ITEMS = 1600;
  localparam int SAT_RUN_MS = 65600;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 12_000_000;

  typedef struct {
    logic action;
    logic [10:0] prob;
    logic [10:0] conf;
    logic signed [11:0] snr;
  } cw_item_t;

  typedef struct {
    logic valid;
    logic is_mark;
    logic [15:0] dur;
    logic [10:0] mconf;
    logic signed [10:0] msnr;
    logic key;
    logic erase;
  } interval_rec_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic action;
  logic [10:0] mark_probability;
  logic [10:0] sample_confidence;
  logic signed [11:0] snr_db;
  logic out_valid;
  logic out_ready;
  logic interval_valid;
  logic interval_is_mark;
  logic [15:0] duration_ms;
  logic [10:0] mean_confidence;
  logic signed [10:0] mean_snr_db;
  logic key_down;
  logic erasure;

  logic [7:0] unit_reg;
  bit run_on;
  bit run_is_mark;
  bit cand_on;
  bit key_reg;
  logic [CNT_W-1:0] run_len;
  logic [CNT_W-1:0] cand_len;
  logic [CNT_W+10:0] run_conf;
  logic [CNT_W+10:0] cand_conf;
  logic signed [CNT_W+11:0] run_snr;
  logic signed [CNT_W+11:0] cand_snr;

  interval_rec_t intervals_due[$];
  int fault_count;
  int items_sent;
  int burst_left;
  bit gaps_on;
  bit stall_on;
  bit hold_request;

  cw_mark_space_run_qualifier u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .mark_probability(mark_probability),
    .sample_confidence(sample_confidence),
    .snr_db(snr_db),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .interval_valid(interval_valid),
    .interval_is_mark(interval_is_mark),
    .duration_ms(duration_ms),
    .mean_confidence(mean_confidence),
    .mean_snr_db(mean_snr_db),
    .key_down(key_down),
    .erasure(erasure)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic cw_item_t sample_of(logic act, int prob, int conf,
                                         logic signed [11:0] snr);
    cw_item_t s;
    s.action = act;
    s.prob = prob;
    s.conf = conf;
    s.snr = snr;
    return s;
  endfunction

  function automatic logic signed [11:0] rand_snr();
    int v;
    if ($urandom_range(0, 9) < 7) v = int'($urandom_range(0, 1280)) - 480;
    else v = int'($urandom_range(0, 4095));
    return v[11:0];
  endfunction

  function automatic void absorb_candidate();
    if (cand_on) begin
      run_len = clip(longint'(run_len) + longint'(cand_len), 0, LEN_SAT);
      run_conf = clip(longint'(run_conf) + longint'(cand_conf), 0, CONF_SAT);
      run_snr = clip(longint'(run_snr) + longint'(cand_snr), SNR_BOT, CONF_SAT);
    end
    cand_on = 1'b0;
    cand_len = '0;
    cand_conf = '0;
    cand_snr = '0;
  endfunction

  function automatic void close_run(inout interval_rec_t r);
    longint len, mc, tot, ms;
    if (!run_on || run_len == 0) return;
    len = run_len;
    mc = (longint'(run_conf) + len / 2) / len;
    if (mc > 1024) mc = 1024;
    tot = run_snr;
    if (tot < 0) ms = -((-tot + len / 2) / len);
    else ms = (tot + len / 2) / len;
    ms = clip(ms, -480, 800);
    r.valid = 1'b1;
    r.is_mark = run_is_mark;
    r.dur = len[15:0];
    r.mconf = mc[10:0];
    r.msnr = ms[10:0];
  endfunction

  function automatic interval_rec_t predict_interval(cw_item_t s);
    interval_rec_t r;
    longint conf, snr, raw, lvl, nominal, unit, span;
    bit decided, want_mark;
    r = '{default: '0};
    if (s.action == ACT_FLUSH) begin
      absorb_candidate();
      close_run(r);
      run_on = 1'b0;
      run_len = '0;
      run_conf = '0;
      run_snr = '0;
    end else begin
      conf = clip(s.conf, 0, 1024);
      snr = clip(s.snr, -480, 800);
      raw = clip(s.prob, 1, 1023);
      lvl = conf * (raw - 512);
      decided = 1'b1;
      want_mark = 1'b0;
      if (lvl >= 123 * 1024) want_mark = 1'b1;
      else if (lvl > -123 * 1024) decided = 1'b0;
      if (!run_on) begin
        if (decided) begin
          run_on = 1'b1;
          run_is_mark = want_mark;
          run_len = 1;
          run_conf = conf;
          run_snr = snr;
          key_reg = want_mark;
        end
      end else if (!decided || want_mark == run_is_mark) begin
        absorb_candidate();
        run_len = clip(longint'(run_len) + 1, 0, LEN_SAT);
        run_conf = clip(longint'(run_conf) + conf, 0, CONF_SAT);
        run_snr = clip(longint'(run_snr) + snr, SNR_BOT, CONF_SAT);
      end else begin
        if (!cand_on) begin
          cand_on = 1'b1;
          cand_len = '0;
          cand_conf = '0;
          cand_snr = '0;
        end
        cand_len = clip(longint'(cand_len) + 1, 0, LEN_SAT);
        cand_conf = clip(longint'(cand_conf) + conf, 0, CONF_SAT);
        cand_snr = clip(longint'(cand_snr) + snr, SNR_BOT, CONF_SAT);
        unit = clip(unit_reg, 24, 240);
        if (run_is_mark) nominal = clip(28 * unit, 700, 2000);
        else nominal = clip(16 * unit, 500, 1200);
        span = (nominal * (110592 - 18 * conf) + 5120000) / 10240000;
        if (cand_len >= span) begin
          close_run(r);
          run_is_mark = !run_is_mark;
          run_len = cand_len;
          run_conf = cand_conf;
          run_snr = cand_snr;
          cand_on = 1'b0;
          cand_len = '0;
          cand_conf = '0;
          cand_snr = '0;
          key_reg = run_is_mark;
        end
      end
    end
    r.key = key_reg;
    r.erase = cand_on;
    return r;
  endfunction

  task automatic send_sample(input cw_item_t s);
    int gap;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    action <= s.action;
    mark_probability <= s.prob;
    sample_confidence <= s.conf;
    snr_db <= s.snr;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    intervals_due.push_back(predict_interval(s));
    items_sent++;
  endtask

  task automatic send_run(input bit as_mark, input int len);
    cw_item_t s;
    int c_eff, off, k;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample(sample_of(ACT_SAMPLE, $urandom_range(0, 2047), $urandom_range(0, 200),
                              rand_snr()));
      end
      c_eff = ($urandom_range(0, 3) == 0) ? 1024 : int'($urandom_range(300, 1024));
      off = (123 * 1024 + c_eff - 1) / c_eff;
      s = sample_of(ACT_SAMPLE, 0, c_eff, rand_snr());
      if (c_eff == 1024 && $urandom_range(0, 1) == 1) s.conf = $urandom_range(1024, 2047);
      if (!as_mark) s.prob = $urandom_range(0, 512 - off);
      else if ($urandom_range(0, 7) == 0) s.prob = $urandom_range(1023, 2047);
      else s.prob = $urandom_range(512 + off, 1023);
      send_sample(s);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (intervals_due.size() != 0);
  endtask

  task automatic write_unit(input logic [7:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unit_reg = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_cases();
    int k;
    send_sample(sample_of(ACT_FLUSH, 0, 0, 0));
    send_sample(sample_of(ACT_SAMPLE, 512, 1024, 0));
    send_sample(sample_of(ACT_SAMPLE, 2047, 2047, 2047));
    send_sample(sample_of(ACT_SAMPLE, 0, 0, -2048));
    send_sample(sample_of(ACT_SAMPLE, 635, 1024, 100));
    send_sample(sample_of(ACT_SAMPLE, 634, 1024, 0));
    send_sample(sample_of(ACT_SAMPLE, 389, 1024, -16));
    send_sample(sample_of(ACT_SAMPLE, 390, 1024, 0));
    send_sample(sample_of(ACT_SAMPLE, 0, 1024, -480));
    send_sample(sample_of(ACT_SAMPLE, 0, 1024, -480));
    send_sample(sample_of(ACT_FLUSH, 2047, 2047, -1));
    send_sample(sample_of(ACT_SAMPLE, 0, 1024, 799));
    for (k = 0; k < 9; k++) send_sample(sample_of(ACT_SAMPLE, 1023, 1024, 400));
    send_sample(sample_of(ACT_FLUSH, 0, 0, 0));
    send_sample(sample_of(ACT_SAMPLE, 1024, 1024, -1));
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int unit_plan [6];
    int phase, start, pick, n, k;
    bit next_mark;
    unit_plan = '{24, 240, 0, 255, 60, 0};
    unit_plan[5] = $urandom_range(25, 239);
    for (phase = 0; phase < 6; phase++) begin
      wait_for_results();
      write_unit(unit_plan[phase]);
      start = items_sent;
      next_mark = $urandom_range(0, 1);
      while (items_sent - start < RANDOM_ITEMS / 6) begin
        pick = $urandom_range(0, 99);
        if (pick < 84) begin
          send_run(next_mark, $urandom_range(1, 28));
          next_mark = !next_mark;
        end else if (pick < 94) begin
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++) begin
            send_sample(sample_of(($urandom_range(0, 7) == 0) ? ACT_FLUSH : ACT_SAMPLE,
                                  $urandom_range(0, 2047), $urandom_range(0, 2047),
                                  $urandom_range(0, 4095)));
          end
        end else begin
          send_sample(sample_of(ACT_FLUSH, $urandom_range(0, 2047), $urandom_range(0, 2047),
                                rand_snr()));
        end
      end
    end
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    int k;
    gaps_on = 1'b0;
    hold_request <= 1'b1;
    for (k = 0; k < 6; k++) send_run(k[0], 10);
    gaps_on = 1'b1;
    wait_for_results();
  endtask

  task automatic test_count_saturation();
    int k;
    gaps_on = 1'b0;
    stall_on = 1'b0;
    send_sample(sample_of(ACT_FLUSH, 0, 0, 0));
    for (k = 0; k < SAT_RUN_MS; k++) send_sample(sample_of(ACT_SAMPLE, 1023, 1024, 800));
    send_sample(sample_of(ACT_FLUSH, 0, 0, 0));
    wait_for_results();
    gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin : rx_pacing
    int stretch_left;
    int held;
    bit hold_done;
    bit rdy;
    out_ready <= 1'b0;
    stretch_left = 0;
    rdy = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        held = 0;
        while (held < LONG_HOLD) begin
          out_ready <= 1'b0;
          @(posedge clk);
          held++;
        end
      end
      if (stretch_left == 0) begin
        rdy = stall_on ? !rdy : 1'b1;
        stretch_left = rdy ? $urandom_range(1, 20) : $urandom_range(1, 7);
      end
      stretch_left--;
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin : check_results
    interval_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (intervals_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("Result transfer with no sample waiting for it.");
      end else begin
        want = intervals_due.pop_front();
        if (want.valid !== interval_valid || want.is_mark !== interval_is_mark ||
            want.dur !== duration_ms || want.mconf !== mean_confidence ||
            want.msnr !== mean_snr_db || want.key !== key_down || want.erase !== erasure) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("Mismatch: expected iv=%0d mark=%0d dur=%0d conf=%0d snr=%0d key=%0d era=%0d",
                     want.valid, want.is_mark, want.dur, want.mconf, want.msnr, want.key,
                     want.erase);
            $display("          actual   iv=%0d mark=%0d dur=%0d conf=%0d snr=%0d key=%0d era=%0d",
                     interval_valid, interval_is_mark, duration_ms, mean_confidence,
                     mean_snr_db, key_down, erasure);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    action <= ACT_SAMPLE;
    mark_probability <= '0;
    sample_confidence <= '0;
    snr_db <= '0;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    burst_left = 0;
    fault_count = 0;
    items_sent = 0;
    unit_reg = UNIT_AT_RESET;
    run_on = 1'b0;
    run_is_mark = 1'b0;
    cand_on = 1'b0;
    key_reg = 1'b0;
    run_len = '0;
    cand_len = '0;
    run_conf = '0;
    cand_conf = '0;
    run_snr = '0;
    cand_snr = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic();
    test_output_backpressure();
    test_count_saturation();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && intervals_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cwmsr_pkg.sv
rtl/cwmsr_serial_div.sv
rtl/cw_mark_space_run_qualifier.sv
verif/cw_mark_space_run_qualifier_tb.sv
